FILE: sv/bc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants of the barometer compensation block
// Field widths, calibration register codes, plausibility limits and the small
// lookup used by the height scaling.
// ----------------------------------------------------------------------------
package bc_pkg;

	localparam int RAW_W      = 24;
	localparam int COEF_W     = 16;
	localparam int NUM_COEFFS = 6;
	localparam int CFG_IDX_W  = 3;

	localparam int DT_W       = RAW_W + 1;
	localparam int PROD_W     = DT_W + COEF_W + 1;
	localparam int SQ_W       = 2 * DT_W;
	localparam int TEMP_W     = 19;
	localparam int PRES_W     = 24;
	localparam int HGT_W      = 32;
	localparam int OFF_W      = 36;
	localparam int SENS_W     = 34;
	localparam int T2_W       = 18;
	localparam int OFF2_W     = 38;
	localparam int SENS2_W    = 36;
	localparam int ESQ_W      = 2 * TEMP_W;
	localparam int SPLIT_W    = 18;
	localparam int PPLO_W     = RAW_W + SPLIT_W;
	localparam int PPHI_W     = RAW_W + 1 + SPLIT_W;
	localparam int PROD2_W    = 61;
	localparam int PR_W       = 42;
	localparam int P_W        = 27;
	localparam int Q_W        = 21;
	localparam int HQ_W       = 31;
	localparam int FRAC_W     = 10;

	localparam int MID_DEPTH  = 8;
	localparam int MID_PTR_W  = 3;
	localparam int MID_CNT_W  = 4;
	localparam int OUT_DEPTH  = 16;
	localparam int OUT_PTR_W  = 4;
	localparam int OUT_CNT_W  = 5;

	// calibration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS     = 3'd0,
		REG_OFF      = 3'd1,
		REG_TCS      = 3'd2,
		REG_TCO      = 3'd3,
		REG_TREF     = 3'd4,
		REG_TEMPSENS = 3'd5
	} reg_idx_t;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sh3FFFF;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = 19'sh40000;
	localparam logic signed [PRES_W-1:0] PRES_MAX = 24'sh7FFFFF;
	localparam logic signed [PRES_W-1:0] PRES_MIN = 24'sh800000;

	// ceil(2^28 / 10): exact quotient for any 24-bit dividend
	localparam logic [DT_W-1:0] RECIP10  = 25'd26843546;
	localparam int              RECIP_SH = 28;
	localparam logic [9:0]      HGT_SCALE = 10'd843;

	localparam logic [COEF_W-1:0] SENS_LO = 16'd40000;
	localparam logic [COEF_W-1:0] SENS_HI = 16'd48000;
	localparam logic [COEF_W-1:0] OFF_LO  = 16'd30000;
	localparam logic [COEF_W-1:0] OFF_HI  = 16'd38000;
	localparam logic [COEF_W-1:0] TC_LO   = 16'd2000;
	localparam logic [COEF_W-1:0] TC_HI   = 16'd4000;
	localparam logic [COEF_W-1:0] REF_LO  = 16'd20000;
	localparam logic [COEF_W-1:0] REF_HI  = 16'd30000;

	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] off;
		logic [COEF_W-1:0] tcs;
		logic [COEF_W-1:0] tco;
		logic [COEF_W-1:0] tref;
		logic [COEF_W-1:0] tempsens;
	} coef_t;

	// first-order terms handed from front to back
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp1;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic [T2_W-1:0]          t2;
		logic                     low;
	} mid_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PRES_W-1:0] pres;
		logic signed [HGT_W-1:0]  hgt;
		logic                     ok;
	} res_t;

	// floor(r * 843 / 10) for a decimal remainder r
	function automatic logic [FRAC_W-1:0] frac843(input logic [3:0] r);
		logic [FRAC_W-1:0] f;
		case (r)
			4'd0: f = 10'd0;
			4'd1: f = 10'd84;
			4'd2: f = 10'd168;
			4'd3: f = 10'd252;
			4'd4: f = 10'd337;
			4'd5: f = 10'd421;
			4'd6: f = 10'd505;
			4'd7: f = 10'd590;
			4'd8: f = 10'd674;
			4'd9: f = 10'd758;
			default: f = '0;
		endcase
		return f;
	endfunction

	function automatic logic in_range(input logic [COEF_W-1:0] v, input logic [COEF_W-1:0] lo,
		input logic [COEF_W-1:0] hi);
		return (v != '0) && (v >= lo) && (v <= hi);
	endfunction

endpackage
`default_nettype wire

FILE: sv/barometer_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// barometer_compensation: second-order barometric sensor compensation
// Calibration registers, calibration check and the front/back datapath.
// ----------------------------------------------------------------------------
// Push a raw pressure/temperature pair while full is low; the compensated
// temperature (0.01 degC), pressure (Pa), height relative to the first sample
// (mm) and the calibration flag come out of the result queue, and the block
// sustains one sample per cycle as long as results are popped. The two halves
// are pipelined around their multiplies: a 2-stage front writing an 8-entry
// term queue, and a 9-stage back writing a 16-entry result queue. The first
// sample after reset sets the height reference and reports zero height.
// Coefficients are written through cfg_we/cfg_index/cfg_data; writes to
// indexes above 5 are dropped, and the calibration check behind calib_ok is
// registered from the stored coefficients.
// ----------------------------------------------------------------------------
module barometer_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [bc_pkg::RAW_W-1:0]         raw_pressure,
	input  logic [bc_pkg::RAW_W-1:0]         raw_temperature,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [bc_pkg::TEMP_W-1:0] temperature_centi,
	output logic signed [bc_pkg::PRES_W-1:0] pressure,
	output logic signed [bc_pkg::HGT_W-1:0]  height_mm,
	output logic                             calib_ok,
	input  logic                             cfg_we,
	input  logic [bc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bc_pkg::COEF_W-1:0]        cfg_data
);
	import bc_pkg::*;

	coef_t coef_q;
	logic  cal_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			cal_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SENS:     coef_q.sens     <= cfg_data;
					REG_OFF:      coef_q.off      <= cfg_data;
					REG_TCS:      coef_q.tcs      <= cfg_data;
					REG_TCO:      coef_q.tco      <= cfg_data;
					REG_TREF:     coef_q.tref     <= cfg_data;
					REG_TEMPSENS: coef_q.tempsens <= cfg_data;
					default: ;
				endcase
			end
			cal_ok_q <= in_range(coef_q.sens, SENS_LO, SENS_HI) &&
				in_range(coef_q.off, OFF_LO, OFF_HI) &&
				in_range(coef_q.tcs, TC_LO, TC_HI) &&
				in_range(coef_q.tco, TC_LO, TC_HI) &&
				in_range(coef_q.tref, REF_LO, REF_HI) &&
				in_range(coef_q.tempsens, REF_LO, REF_HI);
		end
	end

	logic mid_valid;
	logic mid_pop;
	mid_t mid_item;

	bc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.coef            (coef_q),
		.mid_valid       (mid_valid),
		.mid_item        (mid_item),
		.mid_pop         (mid_pop)
	);

	bc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.mid_valid         (mid_valid),
		.mid_item          (mid_item),
		.mid_pop           (mid_pop),
		.cal_ok            (cal_ok_q),
		.empty             (empty),
		.pop               (pop),
		.temperature_centi (temperature_centi),
		.pressure          (pressure),
		.height_mm         (height_mm),
		.calib_ok          (calib_ok)
	);

endmodule
`default_nettype wire

FILE: sv/bc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bc_front: sample intake and first-order terms
// Takes raw conversions, forms dT and the first-order temperature, offset and
// sensitivity, flags the low-temperature case and queues the terms.
// ----------------------------------------------------------------------------
module bc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [bc_pkg::RAW_W-1:0]  raw_pressure,
	input  logic [bc_pkg::RAW_W-1:0]  raw_temperature,
	input  bc_pkg::coef_t             coef,
	output logic                      mid_valid,
	output bc_pkg::mid_t              mid_item,
	input  logic                      mid_pop
);
	import bc_pkg::*;

	logic accept;
	logic [MID_CNT_W-1:0] credit_q;

	// credits cover items in flight plus queued ones
	assign full   = (credit_q == MID_CNT_W'(MID_DEPTH));
	assign accept = push && !full;

	logic signed [DT_W-1:0] dt_in;
	assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.tref, 8'd0});

	logic                   v_s1;
	logic [RAW_W-1:0]       d1_s1;
	logic signed [DT_W-1:0] dt_s1;

	logic                     v_s2;
	logic [RAW_W-1:0]         d1_s2;
	logic signed [PROD_W-1:0] pt_s2;
	logic signed [PROD_W-1:0] poff_s2;
	logic signed [PROD_W-1:0] psens_s2;
	logic signed [SQ_W-1:0]   psq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		d1_s1    <= raw_pressure;
		dt_s1    <= dt_in;
		d1_s2    <= d1_s1;
		pt_s2    <= dt_s1 * $signed({1'b0, coef.tempsens});
		poff_s2  <= dt_s1 * $signed({1'b0, coef.tco});
		psens_s2 <= dt_s1 * $signed({1'b0, coef.tcs});
		psq_s2   <= dt_s1 * dt_s1;
	end

	// first-order terms
	logic signed [OFF_W-1:0]  off_base;
	logic signed [SENS_W-1:0] sens_base;
	mid_t mid_d;

	assign off_base  = {{(OFF_W-COEF_W-16){1'b0}}, coef.off, 16'd0};
	assign sens_base = {{(SENS_W-COEF_W-15){1'b0}}, coef.sens, 15'd0};

	always_comb begin
		mid_d.d1    = d1_s2;
		mid_d.temp1 = TEMP_REF + TEMP_W'(pt_s2 >>> 23);
		mid_d.off   = off_base + OFF_W'(poff_s2 >>> 7);
		mid_d.sens  = sens_base + SENS_W'(psens_s2 >>> 8);
		// dT^2 is never negative, so the shift is a plain bit select
		mid_d.t2    = psq_s2[T2_W+30:31];
		mid_d.low   = (mid_d.temp1 < TEMP_REF);
	end

	mid_t                 mem_q [MID_DEPTH];
	logic [MID_PTR_W-1:0] wr_ptr_q;
	logic [MID_PTR_W-1:0] rd_ptr_q;
	logic [MID_CNT_W-1:0] occ_q;
	logic                 deq;

	assign mid_valid = (occ_q != '0);
	assign mid_item  = mem_q[rd_ptr_q];
	assign deq       = mid_pop && mid_valid;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			mem_q[wr_ptr_q] <= mid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			credit_q <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			occ_q    <= occ_q + MID_CNT_W'(v_s2) - MID_CNT_W'(deq);
			credit_q <= credit_q + MID_CNT_W'(accept) - MID_CNT_W'(deq);
		end
	end

	a_credit_covers_queue: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q >= occ_q)
		else $error("front credits fell below queue occupancy");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (occ_q != MID_CNT_W'(MID_DEPTH)) || deq)
		else $error("term queue written while full");

endmodule
`default_nettype wire

FILE: sv/bc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bc_back: second-order correction, pressure, height and result queue
// Pulls first-order terms, applies the low-temperature correction, computes
// and saturates pressure, latches the reference and scales the height.
// ----------------------------------------------------------------------------
module bc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             mid_valid,
	input  bc_pkg::mid_t                     mid_item,
	output logic                             mid_pop,
	input  logic                             cal_ok,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [bc_pkg::TEMP_W-1:0] temperature_centi,
	output logic signed [bc_pkg::PRES_W-1:0] pressure,
	output logic signed [bc_pkg::HGT_W-1:0]  height_mm,
	output logic                             calib_ok
);
	import bc_pkg::*;

	logic [OUT_CNT_W-1:0] credit_q;
	logic                 take;
	logic                 deq;

	assign take    = mid_valid && (credit_q != OUT_CNT_W'(OUT_DEPTH));
	assign mid_pop = take;

	// ---- stage 1: terms from the queue
	logic v_s1;
	mid_t item_s1;

	// ---- stage 2: square of TEMP-2000, corrected temperature
	logic signed [TEMP_W-1:0] e_s1;
	logic signed [TEMP_W:0]   t2_ext;
	logic signed [ESQ_W-1:0]  esq_full;
	logic                     v_s2;
	logic [ESQ_W-1:0]         esq_s2;
	logic signed [TEMP_W:0]   temp2_s2;
	logic signed [OFF_W-1:0]  off_s2;
	logic signed [SENS_W-1:0] sens_s2;
	logic [RAW_W-1:0]         d1_s2;
	logic                     low_s2;

	assign e_s1     = item_s1.temp1 - TEMP_REF;
	assign esq_full = e_s1 * e_s1;
	assign t2_ext   = item_s1.low ? $signed({{(TEMP_W+1-T2_W){1'b0}}, item_s1.t2}) : '0;

	// ---- stage 3: OFF2/SENS2, temperature saturation
	logic [ESQ_W-1:0]          sq;
	logic signed [OFF2_W-1:0]  off_cor;
	logic signed [SENS2_W-1:0] sens_cor;
	logic signed [TEMP_W-1:0]  temp_sat;
	logic                      v_s3;
	logic signed [OFF2_W-1:0]  off2_s3;
	logic signed [SENS2_W-1:0] sens2_s3;
	logic [RAW_W-1:0]          d1_s3;
	logic signed [TEMP_W-1:0]  temp_s3;

	assign sq       = {esq_s2[ESQ_W-3:0], 2'b00} + esq_s2;
	assign off_cor  = low_s2 ? $signed({1'b0, sq[ESQ_W-1:1]}) : '0;
	assign sens_cor = low_s2 ? $signed({1'b0, sq[SENS2_W:2]}) : '0;

	always_comb begin
		if (temp2_s2 > (TEMP_W+1)'(TEMP_MAX)) begin
			temp_sat = TEMP_MAX;
		end else if (temp2_s2 < (TEMP_W+1)'(TEMP_MIN)) begin
			temp_sat = TEMP_MIN;
		end else begin
			temp_sat = TEMP_W'(temp2_s2);
		end
	end

	// ---- stage 4: D1*SENS split into two partial products
	logic                      v_s4;
	logic [PPLO_W-1:0]         pplo_s4;
	logic signed [PPHI_W-1:0]  pphi_s4;
	logic signed [OFF2_W-1:0]  off2_s4;
	logic signed [TEMP_W-1:0]  temp_s4;

	// ---- stage 5: partial products summed
	logic                      v_s5;
	logic signed [PROD2_W-1:0] prod_s5;
	logic signed [OFF2_W-1:0]  off2_s5;
	logic signed [TEMP_W-1:0]  temp_s5;

	// ---- stage 6: pressure and saturation
	logic signed [PR_W-1:0]    pr;
	logic signed [P_W-1:0]     pv;
	logic signed [PRES_W-1:0]  p_sat;
	logic                      v_s6;
	logic signed [PRES_W-1:0]  p_s6;
	logic signed [TEMP_W-1:0]  temp_s6;

	assign pr = PR_W'(prod_s5 >>> 21) - PR_W'(off2_s5);
	assign pv = P_W'(pr >>> 15);

	always_comb begin
		if (pv > P_W'(PRES_MAX)) begin
			p_sat = PRES_MAX;
		end else if (pv < P_W'(PRES_MIN)) begin
			p_sat = PRES_MIN;
		end else begin
			p_sat = PRES_W'(pv);
		end
	end

	// ---- stage 7: difference to the reference, magnitude and sign
	logic                      ref_taken_q;
	logic signed [PRES_W-1:0]  ref_p_q;
	logic signed [PRES_W-1:0]  p0;
	logic signed [DT_W-1:0]    dp;
	logic signed [DT_W-1:0]    dp_abs;
	logic                      v_s7;
	logic [RAW_W-1:0]          mag_s7;
	logic                      neg_s7;
	logic signed [PRES_W-1:0]  p_s7;
	logic signed [TEMP_W-1:0]  temp_s7;

	// the first sample is its own reference
	assign p0     = ref_taken_q ? ref_p_q : p_s6;
	assign dp     = DT_W'(p_s6) - DT_W'(p0);
	assign dp_abs = dp[DT_W-1] ? -dp : dp;

	// ---- stage 8: quotient by ten through the reciprocal
	logic [RAW_W+DT_W-1:0]     qprod;
	logic                      v_s8;
	logic [Q_W-1:0]            q_s8;
	logic [RAW_W-1:0]          mag_s8;
	logic                      neg_s8;
	logic signed [PRES_W-1:0]  p_s8;
	logic signed [TEMP_W-1:0]  temp_s8;

	assign qprod = mag_s7 * RECIP10;

	// ---- stage 9: q*843 plus the scaled remainder
	logic [RAW_W-1:0]          q10;
	logic [RAW_W-1:0]          rem;
	logic                      v_s9;
	logic [HQ_W-1:0]           hq_s9;
	logic [FRAC_W-1:0]         frac_s9;
	logic                      neg_s9;
	logic signed [PRES_W-1:0]  p_s9;
	logic signed [TEMP_W-1:0]  temp_s9;

	assign q10 = {q_s8, 3'b000} + {2'b00, q_s8, 1'b0};
	assign rem = mag_s8 - q10;

	// ---- result assembly
	logic [HGT_W-1:0] hmag;
	res_t             res_d;

	assign hmag = {1'b0, hq_s9} + {{(HGT_W-FRAC_W){1'b0}}, frac_s9};

	always_comb begin
		res_d.temp = temp_s9;
		res_d.pres = p_s9;
		// height runs opposite to the pressure change
		res_d.hgt  = neg_s9 ? $signed(hmag) : -$signed(hmag);
		res_d.ok   = cal_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			ref_taken_q <= 1'b0;
			ref_p_q     <= '0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			if (v_s6 && !ref_taken_q) begin
				ref_taken_q <= 1'b1;
				ref_p_q     <= p_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s1  <= mid_item;

		esq_s2   <= esq_full;
		temp2_s2 <= (TEMP_W+1)'(item_s1.temp1) - t2_ext;
		off_s2   <= item_s1.off;
		sens_s2  <= item_s1.sens;
		d1_s2    <= item_s1.d1;
		low_s2   <= item_s1.low;

		off2_s3  <= OFF2_W'(off_s2) - off_cor;
		sens2_s3 <= SENS2_W'(sens_s2) - sens_cor;
		d1_s3    <= d1_s2;
		temp_s3  <= temp_sat;

		pplo_s4  <= d1_s3 * sens2_s3[SPLIT_W-1:0];
		pphi_s4  <= $signed({1'b0, d1_s3}) * $signed(sens2_s3[SENS2_W-1:SPLIT_W]);
		off2_s4  <= off2_s3;
		temp_s4  <= temp_s3;

		prod_s5  <= (PROD2_W'(pphi_s4) <<< SPLIT_W) + PROD2_W'($signed({1'b0, pplo_s4}));
		off2_s5  <= off2_s4;
		temp_s5  <= temp_s4;

		p_s6     <= p_sat;
		temp_s6  <= temp_s5;

		mag_s7   <= dp_abs[RAW_W-1:0];
		neg_s7   <= dp[DT_W-1];
		p_s7     <= p_s6;
		temp_s7  <= temp_s6;

		q_s8     <= qprod[RECIP_SH+Q_W-1:RECIP_SH];
		mag_s8   <= mag_s7;
		neg_s8   <= neg_s7;
		p_s8     <= p_s7;
		temp_s8  <= temp_s7;

		hq_s9    <= q_s8 * HGT_SCALE;
		frac_s9  <= frac843(rem[3:0]);
		neg_s9   <= neg_s8;
		p_s9     <= p_s8;
		temp_s9  <= temp_s8;
	end

	// result queue
	res_t                 mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] occ_q;
	res_t                 head;

	assign empty             = (occ_q == '0);
	assign deq               = pop && !empty;
	assign head              = mem_q[rd_ptr_q];
	assign temperature_centi = head.temp;
	assign pressure          = head.pres;
	assign height_mm         = head.hgt;
	assign calib_ok          = head.ok;

	always_ff @(posedge clk) begin
		if (v_s9) begin
			mem_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			credit_q <= '0;
		end else begin
			if (v_s9) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			occ_q    <= occ_q + OUT_CNT_W'(v_s9) - OUT_CNT_W'(deq);
			credit_q <= credit_q + OUT_CNT_W'(take) - OUT_CNT_W'(deq);
		end
	end

	a_credit_covers_queue: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q >= occ_q)
		else $error("back credits fell below result queue occupancy");

	a_ref_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ref_taken_q) |-> $past(v_s6))
		else $error("reference latched without a sample");

	a_ref_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ref_taken_q |=> ref_taken_q && $stable(ref_p_q))
		else $error("reference pressure changed after first sample");

endmodule
`default_nettype wire
